/* rtl/aasd_pkg.sv */
// package for the accelerometer activity and shake detector
// types, constants and helper functions used by controller, datapath and top level
// no dependencies
package aasd_pkg;

   localparam int ENERGY_WINDOW_DEF = 50;
   localparam int SHAKE_WINDOW_DEF  = 75;

   localparam int GW = 34;              // gravity, signed q18.16 mg

   localparam logic [16:0] ALPHA_Q16 = 17'd65208;
   localparam logic [8:0]  GAIN_Q16  = 9'd328;
   localparam logic signed [GW-1:0] GRAV_Z_RESET = 34'sd65536000;

   localparam logic [2:0] CSR_SHAKE_LEVEL   = 3'd0;
   localparam logic [2:0] CSR_SHAKE_MIN     = 3'd1;
   localparam logic [2:0] CSR_SHAKE_LOCKOUT = 3'd2;
   localparam logic [2:0] CSR_MOTION_LEVEL  = 3'd3;
   localparam logic [2:0] CSR_MOTION_GAP    = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_AXIS,       // gravity multiply for the current axis
      ST_AXIS2,      // round gravity, linear value
      ST_SQ,         // square one axis
      ST_STORE,      // write rings, motion, lockout
      ST_PICK,       // branch on scan and report flags
      ST_SCAN_RD,    // shake ring scan
      ST_SUM_RD,     // energy ring sum
      ST_CLASS,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic axis_mul;
      logic axis_fin;
      logic sq;
      logic store;
      logic scan_step;
      logic sum_step;
      logic classify;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic axis_last;
      logic scan_go;
      logic scan_done;
      logic report_go;
      logic sum_done;
   } sts_type;

   // mean >= bound is the same as window sum >= n * bound
   function automatic logic [2:0] class_of(input logic [63:0] s, input logic [63:0] n);
      logic [2:0] c;
      c = 3'd0;
      if (s >= n * 64'd520)   c = 3'd1;
      if (s >= n * 64'd5200)  c = 3'd2;
      if (s >= n * 64'd20797) c = 3'd3;
      if (s >= n * 64'd51992) c = 3'd4;
      return c;
   endfunction

   function automatic logic [3:0] inten_of(input logic [63:0] s, input logic [63:0] n);
      logic [3:0] k;
      k = 4'd1;
      if (s >= n * 64'd4290)  k = k + 4'd1;
      if (s >= n * 64'd8093)  k = k + 4'd1;
      if (s >= n * 64'd12881) k = k + 4'd1;
      if (s >= n * 64'd18908) k = k + 4'd1;
      if (s >= n * 64'd26497) k = k + 4'd1;
      if (s >= n * 64'd36049) k = k + 4'd1;
      if (s >= n * 64'd48076) k = k + 4'd1;
      if (s >= n * 64'd63216) k = k + 4'd1;
      if (s >= n * 64'd82276) k = k + 4'd1;
      return k;
   endfunction

endpackage

/* rtl/aasd_ctrl.sv */
// controller state machine of the activity and shake detector
// depends on aasd_pkg
module aasd_ctrl import aasd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_fire,
   input  logic    out_free,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    busy
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (in_fire) state_in = ST_AXIS;
         ST_AXIS:    state_in = ST_AXIS2;
         ST_AXIS2:   state_in = ST_SQ;
         ST_SQ:      state_in = sts.axis_last ? ST_STORE : ST_AXIS;
         ST_STORE:   state_in = ST_PICK;
         ST_PICK: begin
            if (sts.scan_go)        state_in = ST_SCAN_RD;
            else if (sts.report_go) state_in = ST_SUM_RD;
            else                    state_in = ST_OUT;
         end
         ST_SCAN_RD: begin
            if (sts.scan_done) state_in = sts.report_go ? ST_SUM_RD : ST_OUT;
         end
         ST_SUM_RD:  if (sts.sum_done) state_in = ST_CLASS;
         ST_CLASS:   state_in = ST_OUT;
         ST_OUT:     if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_IDLE:    begin busy = 1'b0; cmd.start = in_fire; end
         ST_AXIS:    cmd.axis_mul = 1'b1;
         ST_AXIS2:   cmd.axis_fin = 1'b1;
         ST_SQ:      cmd.sq = 1'b1;
         ST_STORE:   cmd.store = 1'b1;
         ST_PICK:    ;
         ST_SCAN_RD: cmd.scan_step = 1'b1;
         ST_SUM_RD:  cmd.sum_step = 1'b1;
         ST_CLASS:   cmd.classify = 1'b1;
         ST_OUT:     cmd.load_out = out_free;
         default:    busy = 1'b1;
      endcase
   end

endmodule

/* rtl/aasd_dp.sv */
// datapath of the activity and shake detector: gravity filters, rings, scan,
// energy sum and classification; depends on aasd_pkg
module aasd_dp import aasd_pkg::*; #(
   parameter int ENERGY_WINDOW = ENERGY_WINDOW_DEF,
   parameter int SHAKE_WINDOW  = SHAKE_WINDOW_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic signed [15:0] accel_x,
   input  logic signed [15:0] accel_y,
   input  logic signed [15:0] accel_z,
   input  logic [14:0]        shake_level_mg,
   input  logic [6:0]         shake_min_crossings,
   input  logic [15:0]        shake_lockout_samples,
   input  logic [31:0]        motion_level_sq,
   input  logic [7:0]         motion_gap_samples,
   output logic               motion_event,
   output logic               shake_event,
   output logic               report_valid,
   output logic [2:0]         activity_class,
   output logic [3:0]         intensity
);

   localparam int EW = (ENERGY_WINDOW > 1) ? $clog2(ENERGY_WINDOW) : 1;
   localparam int SW = (SHAKE_WINDOW > 1) ? $clog2(SHAKE_WINDOW) : 1;
   localparam int SCW = $clog2(SHAKE_WINDOW + 1);
   localparam int ECW = $clog2(ENERGY_WINDOW + 1);
   localparam int SUMW = 32 + ECW;
   localparam logic [EW-1:0] E_LAST = EW'(ENERGY_WINDOW - 1);
   localparam logic [SW-1:0] S_LAST = SW'(SHAKE_WINDOW - 1);

   // captured sample
   logic signed [15:0] ax_ff [3];
   logic signed [GW-1:0] grav_ff [3];
   logic [1:0] axis_ff;
   logic signed [51:0] prod_ff;     // alpha * gravity + gain * a * 2^16
   logic signed [17:0] lin_ff [3];
   logic [33:0] sq_acc_ff;

   // rings
   logic [31:0] energy_mem [ENERGY_WINDOW];
   logic signed [17:0] shake_mem [SHAKE_WINDOW];
   logic [EW-1:0] epos_ff, eidx_ff;
   logic [SW-1:0] spos_ff, sidx_ff;
   logic [SCW-1:0] sfill_ff, scnt_ff;
   logic [ECW-1:0] ecnt_ff;
   logic [ECW-1:0] tick_ff;
   logic [15:0] lock_ff;
   logic [7:0] since_ff;
   logic scan_go_ff, report_go_ff;

   // scan
   logic [SCW-1:0] cross_ff;
   logic [1:0] last_sign_ff;        // 00 none, 01 positive, 11 negative
   logic [SUMW-1:0] sum_ff;
   logic [2:0] class_ff;

   logic motion_ff, shake_ff, report_ff;
   logic [3:0] inten_ff;

   // per-axis filter arithmetic
   logic signed [GW-1:0] g_cur;
   logic signed [15:0] a_cur;
   logic signed [51:0] g_round;
   logic signed [GW-1:0] g_new;
   logic signed [51:0] lin_full;
   logic signed [17:0] lin_cur;
   logic signed [35:0] lin_sq;
   logic [31:0] sq32;

   always_comb begin
      g_cur    = grav_ff[axis_ff];
      a_cur    = ax_ff[axis_ff];
      g_round  = (prod_ff + 52'sd32768) >>> 16;
      g_new    = g_round[GW-1:0];
      lin_full = ((52'(a_cur) <<< 16) - 52'(g_new) + 52'sd32768) >>> 16;
      lin_cur  = lin_full[17:0];
      lin_sq   = lin_ff[axis_ff] * lin_ff[axis_ff];
      sq32     = (sq_acc_ff[33:32] != 2'b00) ? 32'hFFFF_FFFF : sq_acc_ff[31:0];
   end

   // ring reads, registered
   logic signed [17:0] s_rd_ff;
   logic [31:0] e_rd_ff;
   logic s_rd_v_ff, e_rd_v_ff;

   always_ff @(posedge clock) begin
      if (cmd.scan_step) s_rd_ff <= shake_mem[sidx_ff];
      if (cmd.sum_step)  e_rd_ff <= energy_mem[eidx_ff];
      if (cmd.store) begin
         energy_mem[epos_ff] <= sq32;
         shake_mem[spos_ff]  <= lin_ff[2];
      end
   end

   logic [17:0] s_mag;
   logic s_big;
   logic [1:0] s_sign;
   always_comb begin
      s_mag  = s_rd_ff[17] ? 18'(-s_rd_ff) : 18'(s_rd_ff);
      s_big  = s_mag >= {3'b000, shake_level_mg};
      s_sign = (s_rd_ff > 18'sd0) ? 2'b01 : 2'b11;
   end

   logic [15:0] lock_dec;
   logic [7:0]  since_inc;
   logic [ECW-1:0] tick_inc;
   always_comb begin
      lock_dec  = (lock_ff != 16'd0) ? lock_ff - 16'd1 : 16'd0;
      since_inc = (since_ff != 8'hFF) ? since_ff + 8'd1 : since_ff;
      tick_inc  = tick_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grav_ff[0]   <= '0;
         grav_ff[1]   <= '0;
         grav_ff[2]   <= GRAV_Z_RESET;
         epos_ff      <= '0;
         spos_ff      <= '0;
         sfill_ff     <= '0;
         tick_ff      <= '0;
         lock_ff      <= '0;
         since_ff     <= 8'hFF;
         class_ff     <= '0;
         axis_ff      <= '0;
         scnt_ff      <= '0;
         ecnt_ff      <= '0;
         s_rd_v_ff    <= 1'b0;
         e_rd_v_ff    <= 1'b0;
         scan_go_ff   <= 1'b0;
         report_go_ff <= 1'b0;
         motion_event <= 1'b0;
         shake_event  <= 1'b0;
         report_valid <= 1'b0;
         activity_class <= '0;
         intensity    <= '0;
      end else begin
         if (cmd.start) begin
            ax_ff[0]  <= accel_x;
            ax_ff[1]  <= accel_y;
            ax_ff[2]  <= accel_z;
            axis_ff   <= '0;
            sq_acc_ff <= '0;
            motion_ff <= 1'b0;
            shake_ff  <= 1'b0;
            report_ff <= 1'b0;
            inten_ff  <= '0;
         end
         if (cmd.axis_mul) begin
            prod_ff <= 52'(g_cur) * $signed({35'd0, ALPHA_Q16})
                     + (52'(a_cur) <<< 16) * $signed({43'd0, GAIN_Q16});
         end
         if (cmd.axis_fin) begin
            grav_ff[axis_ff] <= g_new;
            lin_ff[axis_ff]  <= lin_cur;
         end
         if (cmd.sq) begin
            sq_acc_ff <= sq_acc_ff + 34'(unsigned'(lin_sq));
            axis_ff   <= axis_ff + 2'd1;
         end
         if (cmd.store) begin
            epos_ff  <= (epos_ff == E_LAST) ? '0 : epos_ff + 1'b1;
            spos_ff  <= (spos_ff == S_LAST) ? '0 : spos_ff + 1'b1;
            sidx_ff  <= (spos_ff == S_LAST) ? '0 : spos_ff + 1'b1;
            if (sfill_ff < SCW'(SHAKE_WINDOW)) sfill_ff <= sfill_ff + 1'b1;
            if (sq32 > motion_level_sq && since_inc >= motion_gap_samples) begin
               motion_ff <= 1'b1;
               since_ff  <= '0;
            end else begin
               since_ff  <= since_inc;
            end
            lock_ff <= lock_dec;
            scan_go_ff <= (sfill_ff >= SCW'(SHAKE_WINDOW - 1)) && (lock_dec == 16'd0);
            if (tick_inc >= ECW'(ENERGY_WINDOW)) begin
               tick_ff      <= '0;
               report_go_ff <= 1'b1;
            end else begin
               tick_ff      <= tick_inc;
               report_go_ff <= 1'b0;
            end
            scnt_ff      <= '0;
            ecnt_ff      <= '0;
            eidx_ff      <= '0;
            cross_ff     <= '0;
            last_sign_ff <= 2'b00;
            sum_ff       <= '0;
            s_rd_v_ff    <= 1'b0;
            e_rd_v_ff    <= 1'b0;
         end
         if (cmd.scan_step) begin
            // issue reads, then consume each registered word in the following cycle
            if (scnt_ff < SCW'(SHAKE_WINDOW)) begin
               sidx_ff <= (sidx_ff == S_LAST) ? '0 : sidx_ff + 1'b1;
               scnt_ff <= scnt_ff + 1'b1;
            end
            s_rd_v_ff <= scnt_ff < SCW'(SHAKE_WINDOW);
            if (s_rd_v_ff && s_big) begin
               if (last_sign_ff != 2'b00 && last_sign_ff != s_sign)
                  cross_ff <= cross_ff + 1'b1;
               last_sign_ff <= s_sign;
            end
            // last word is consumed before scan_done rises
            if (sts.scan_done && 32'(cross_ff) >= 32'(shake_min_crossings)) begin
               shake_ff <= 1'b1;
               lock_ff  <= shake_lockout_samples;
            end
         end
         if (cmd.sum_step) begin
            if (ecnt_ff < ECW'(ENERGY_WINDOW)) begin
               eidx_ff <= eidx_ff + 1'b1;
               ecnt_ff <= ecnt_ff + 1'b1;
            end
            e_rd_v_ff <= ecnt_ff < ECW'(ENERGY_WINDOW);
            if (e_rd_v_ff) sum_ff <= sum_ff + SUMW'(e_rd_ff);
         end
         if (cmd.classify) begin
            class_ff  <= class_of(64'(sum_ff), 64'(ENERGY_WINDOW));
            inten_ff  <= inten_of(64'(sum_ff), 64'(ENERGY_WINDOW));
            report_ff <= 1'b1;
         end
         if (cmd.load_out) begin
            motion_event   <= motion_ff;
            shake_event    <= shake_ff;
            report_valid   <= report_ff;
            activity_class <= report_ff ? class_ff : class_ff;
            intensity      <= inten_ff;
         end
      end
   end

   always_comb begin
      sts.axis_last = (axis_ff == 2'd2);
      sts.scan_go   = scan_go_ff;
      sts.report_go = report_go_ff;
      sts.scan_done = (scnt_ff == SCW'(SHAKE_WINDOW)) && !s_rd_v_ff;
      sts.sum_done  = (ecnt_ff == ECW'(ENERGY_WINDOW)) && !e_rd_v_ff;
   end

endmodule

/* rtl/accel_activity_shake_detector_unit.sv */
// top level of the accelerometer activity and shake detector
// instantiates aasd_ctrl and aasd_dp, uses aasd_pkg
//
// one three-axis sample (signed mg) per transaction in, one result per
// transaction out. gravity per axis is tracked by a q16 low-pass, linear
// acceleration drives a throttled motion flag, linear z feeds a shake ring that
// is scanned for sign changes, and every ENERGY_WINDOW samples the mean energy
// is reported as a class and an intensity. the three axes pass one after
// another through the same filter arithmetic; the shake ring, when it is
// scanned, and the energy ring, on a report sample, are read one word at a
// time, and a result is held until rsp_tready takes it. the mean is never
// divided out: the window sum is compared against bounds scaled by
// ENERGY_WINDOW. one sample is worked on at a time.
module accel_activity_shake_detector_unit import aasd_pkg::*; #(
   parameter int ENERGY_WINDOW = ENERGY_WINDOW_DEF,
   parameter int SHAKE_WINDOW  = SHAKE_WINDOW_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // accel_x, accel_y, accel_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // motion_event, shake_event, report_valid,
                                    // activity_class[2:0], intensity[3:0], zeros
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // configuration registers
   logic [14:0] shake_level_ff;
   logic [6:0]  shake_min_ff;
   logic [15:0] shake_lock_ff;
   logic [31:0] motion_level_ff;
   logic [7:0]  motion_gap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shake_level_ff  <= 15'd612;
         shake_min_ff    <= 7'd4;
         shake_lock_ff   <= 16'd125;
         motion_level_ff <= 32'd23397;
         motion_gap_ff   <= 8'd5;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SHAKE_LEVEL:   shake_level_ff  <= csr_wdata[14:0];
            CSR_SHAKE_MIN:     shake_min_ff    <= csr_wdata[6:0];
            CSR_SHAKE_LOCKOUT: shake_lock_ff   <= csr_wdata[15:0];
            CSR_MOTION_LEVEL:  motion_level_ff <= csr_wdata;
            CSR_MOTION_GAP:    motion_gap_ff   <= csr_wdata[7:0];
            default:           ;
         endcase
      end
   end

   cmd_type cmd;
   sts_type sts;
   logic busy;
   logic in_fire;
   logic out_free;

   // output register: holds a result until the transaction completes
   logic rsp_valid_ff;
   logic motion_w, shake_w, report_w;
   logic [2:0] class_w;
   logic [3:0] inten_w;

   assign req_tready = !busy;
   assign in_fire    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, inten_w, class_w, report_w, shake_w, motion_w};

   aasd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_fire  (in_fire),
      .out_free (out_free),
      .sts      (sts),
      .cmd      (cmd),
      .busy     (busy)
   );

   aasd_dp #(
      .ENERGY_WINDOW (ENERGY_WINDOW),
      .SHAKE_WINDOW  (SHAKE_WINDOW)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .accel_x               (req_tdata[15:0]),
      .accel_y               (req_tdata[31:16]),
      .accel_z               (req_tdata[47:32]),
      .shake_level_mg        (shake_level_ff),
      .shake_min_crossings   (shake_min_ff),
      .shake_lockout_samples (shake_lock_ff),
      .motion_level_sq       (motion_level_ff),
      .motion_gap_samples    (motion_gap_ff),
      .motion_event          (motion_w),
      .shake_event           (shake_w),
      .report_valid          (report_w),
      .activity_class        (class_w),
      .intensity             (inten_w)
   );

endmodule
